FILE: sv/ibp_pkg.sv
// Package for the intra block predictor: request and mode codes, state type,
// the capture control struct and shared widths. No dependencies.
package ibp_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int NUM_SAMPLES = 16;
    localparam int IDX_W       = 4;
    localparam int SUM_W       = 12;
    localparam int POS_W       = 5;
    localparam int PIX_W       = 64;

    localparam logic [SAMPLE_W-1:0] DC_NONE_VALUE = 8'h80;

    localparam logic [1:0] REQ_LOAD_TOP  = 2'd0;
    localparam logic [1:0] REQ_LOAD_LEFT = 2'd1;
    localparam logic [1:0] REQ_PREDICT   = 2'd2;

    localparam logic [2:0] MODE_DC         = 3'd0;
    localparam logic [2:0] MODE_VERTICAL   = 3'd1;
    localparam logic [2:0] MODE_HORIZONTAL = 3'd2;
    localparam logic [2:0] MODE_DC_NO_TOP  = 3'd3;
    localparam logic [2:0] MODE_DC_NO_LEFT = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_EMIT
    } ibp_state_t;

    // Control from the sequencer to the neighbour capture unit.
    typedef struct packed {
        logic             clear;
        logic             valid;
        logic [IDX_W-1:0] index;
    } cap_ctrl_t;

    typedef logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] sample_row_t;

endpackage

FILE: sv/ibp_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module ibp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/ibp_capture.sv
// Neighbour capture: accumulates the top and left sums during the read sweep
// and keeps a copy of the samples for the row generator. Uses ibp_pkg.
module ibp_capture
    import ibp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cap_ctrl_t           ctrl,
    input  logic [SAMPLE_W-1:0] top_rd,
    input  logic [SAMPLE_W-1:0] left_rd,
    output logic [SUM_W-1:0]    sum_top,
    output logic [SUM_W-1:0]    sum_left,
    output sample_row_t         top_row,
    output sample_row_t         left_col
);

    logic [SUM_W-1:0] sum_top_reg;
    logic [SUM_W-1:0] sum_left_reg;
    sample_row_t      top_row_reg;
    sample_row_t      left_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_top_reg  <= '0;
            sum_left_reg <= '0;
        end else if (ctrl.clear) begin
            sum_top_reg  <= '0;
            sum_left_reg <= '0;
        end else if (ctrl.valid) begin
            sum_top_reg  <= sum_top_reg + SUM_W'(top_rd);
            sum_left_reg <= sum_left_reg + SUM_W'(left_rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.valid) begin
            top_row_reg[ctrl.index]  <= top_rd;
            left_col_reg[ctrl.index] <= left_rd;
        end
    end

    assign sum_top  = sum_top_reg;
    assign sum_left = sum_left_reg;
    assign top_row  = top_row_reg;
    assign left_col = left_col_reg;

endmodule

FILE: sv/ibp_out_stage.sv
// Row generator and output register: walks the row halves of the block and
// forms each 8-pixel word from the captured neighbours. Uses ibp_pkg.
module ibp_out_stage
    import ibp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                emit_active,
    input  logic [2:0]          mode,
    input  logic                large_blk,
    input  logic [SUM_W-1:0]    sum_top,
    input  logic [SUM_W-1:0]    sum_left,
    input  sample_row_t         top_row,
    input  sample_row_t         left_col,
    output logic                done,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [71:0]         m_tdata,   // row_index[3:0], half_index, pixels[63:0], zero pad
    output logic                m_tlast
);

    logic [POS_W-1:0]    pos_reg;
    logic                m_tvalid_reg;
    logic [71:0]         m_tdata_reg;
    logic                m_tlast_reg;

    logic                load;
    logic                is_last;
    logic [IDX_W-1:0]    row;
    logic                half;
    logic [SUM_W:0]      sum_both;
    logic [SUM_W:0]      dc_full;
    logic [SUM_W-1:0]    dc_left;
    logic [SUM_W-1:0]    dc_top;
    logic [SAMPLE_W-1:0] dc_value;
    logic [PIX_W-1:0]    pixels;

    assign load    = emit_active && (!m_tvalid_reg || m_tready);
    assign is_last = large_blk ? (pos_reg == POS_W'(31)) : (pos_reg == POS_W'(7));
    assign row     = large_blk ? pos_reg[4:1] : {1'b0, pos_reg[2:0]};
    assign half    = large_blk ? pos_reg[0] : 1'b0;

    // Rounded means; the shift depends on the block size.
    always_comb begin
        sum_both = (SUM_W+1)'(sum_top) + (SUM_W+1)'(sum_left);
        if (large_blk) begin
            dc_full = (sum_both + (SUM_W+1)'(16)) >> 5;
            dc_left = (sum_left + SUM_W'(8)) >> 4;
            dc_top  = (sum_top + SUM_W'(8)) >> 4;
        end else begin
            dc_full = (sum_both + (SUM_W+1)'(8)) >> 4;
            dc_left = (sum_left + SUM_W'(4)) >> 3;
            dc_top  = (sum_top + SUM_W'(4)) >> 3;
        end
        case (mode)
            MODE_DC:         dc_value = dc_full[SAMPLE_W-1:0];
            MODE_DC_NO_TOP:  dc_value = dc_left[SAMPLE_W-1:0];
            MODE_DC_NO_LEFT: dc_value = dc_top[SAMPLE_W-1:0];
            default:         dc_value = DC_NONE_VALUE;
        endcase
        case (mode)
            MODE_VERTICAL:   pixels = half ? PIX_W'(top_row[15:8]) : PIX_W'(top_row[7:0]);
            MODE_HORIZONTAL: pixels = {8{left_col[row]}};
            default:         pixels = {8{dc_value}};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_tvalid_reg <= 1'b1;
                pos_reg      <= is_last ? '0 : pos_reg + POS_W'(1);
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {3'b000, pixels, half, row};
            m_tlast_reg <= is_last;
        end
    end

    assign done     = load && is_last;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: sv/intra_block_predictor_top.sv
// Intra block predictor top level: request decoder and sweep sequencer over
// the two neighbour RAMs. Uses ibp_pkg, ibp_ram, ibp_capture, ibp_out_stage.
//
//  Channel | Ports                               | Carries
//  --------+-------------------------------------+---------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser   | load top, load left, predict
//  result  | m_tvalid m_tready m_tdata m_tlast   | 8-pixel row halves of the block
//
// A load request writes one RAM entry.
// A predict request reads the N neighbours one per cycle from both RAMs
// (N = 16 or 8), then emits one row half per cycle while m_tready is high:
// 32 results for 16x16, 8 for 8x8. The single RAM read port sets the sweep.
// The input is not ready during a predict; back-pressure on the result side
// stalls the emission. Reset clears the control state; the RAMs are not cleared.
module intra_block_predictor_top
    import ibp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample_index[3:0], sample_value[7:0], pred_mode[2:0], large_block
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // row_index[3:0], half_index, pixels[63:0], zero pad
    output logic        m_tlast
);

    ibp_state_t state_reg, state_next;

    logic [IDX_W-1:0]    s_index;
    logic [SAMPLE_W-1:0] s_value;
    logic [2:0]          s_mode;
    logic                s_large;
    logic                accept;

    logic [2:0]   mode_reg;
    logic         large_reg;
    logic [POS_W-1:0] sweep_cnt_reg;
    logic         rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [POS_W-1:0] n_samples;
    logic         rd_issue;

    logic                top_we;
    logic                left_we;
    logic [SAMPLE_W-1:0] top_rd;
    logic [SAMPLE_W-1:0] left_rd;
    cap_ctrl_t           cap_ctrl;
    logic [SUM_W-1:0]    sum_top;
    logic [SUM_W-1:0]    sum_left;
    sample_row_t         top_row;
    sample_row_t         left_col;
    logic                emit_done;

    assign s_index = s_tdata[3:0];
    assign s_value = s_tdata[11:4];
    assign s_mode  = s_tdata[14:12];
    assign s_large = s_tdata[15];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign top_we   = accept && (s_tuser == REQ_LOAD_TOP);
    assign left_we  = accept && (s_tuser == REQ_LOAD_LEFT);

    assign n_samples = large_reg ? POS_W'(16) : POS_W'(8);
    assign rd_issue  = (state_reg == ST_SWEEP) && (sweep_cnt_reg < n_samples);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == REQ_PREDICT) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                // The last RAM read has landed once nothing is pending.
                if (sweep_cnt_reg == n_samples && !rd_pend_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
        end else begin
            rd_pend_reg <= rd_issue;
            if (accept && s_tuser == REQ_PREDICT) begin
                sweep_cnt_reg <= '0;
            end else if (rd_issue) begin
                sweep_cnt_reg <= sweep_cnt_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= sweep_cnt_reg[IDX_W-1:0];
        if (accept && s_tuser == REQ_PREDICT) begin
            mode_reg  <= s_mode;
            large_reg <= s_large;
        end
    end

    assign cap_ctrl.clear = accept && (s_tuser == REQ_PREDICT);
    assign cap_ctrl.valid = rd_pend_reg;
    assign cap_ctrl.index = rd_idx_reg;

    ibp_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_SAMPLES)) u_top_ram (
        .aclk  (aclk),
        .we    (top_we),
        .waddr (s_index),
        .wdata (s_value),
        .raddr (sweep_cnt_reg[IDX_W-1:0]),
        .rdata (top_rd)
    );

    ibp_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_SAMPLES)) u_left_ram (
        .aclk  (aclk),
        .we    (left_we),
        .waddr (s_index),
        .wdata (s_value),
        .raddr (sweep_cnt_reg[IDX_W-1:0]),
        .rdata (left_rd)
    );

    ibp_capture u_capture (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (cap_ctrl),
        .top_rd   (top_rd),
        .left_rd  (left_rd),
        .sum_top  (sum_top),
        .sum_left (sum_left),
        .top_row  (top_row),
        .left_col (left_col)
    );

    ibp_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .emit_active (state_reg == ST_EMIT),
        .mode        (mode_reg),
        .large_blk   (large_reg),
        .sum_top     (sum_top),
        .sum_left    (sum_left),
        .top_row     (top_row),
        .left_col    (left_col),
        .done        (emit_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

FILE: sv/ibp_checker.sv
// Port-level checks for the intra block predictor, bound to the top level.
// Uses ibp_pkg for the request codes.
module ibp_checker
    import ibp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);

    // A predict request occupies the block, so the input closes next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == REQ_PREDICT |=> !s_tready)
        else $error("input still ready after a predict request");

    // Any other request is finished in its own cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != REQ_PREDICT |=> s_tready)
        else $error("input closed after a load request");

    // Results only appear while a predict request is being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a predict request");

    // The final result is the right half of row 15 or the only half of row 7.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[4:0] == 5'h07 || m_tdata[4:0] == 5'h1F))
        else $error("last marker on the wrong row half");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind intra_block_predictor_top ibp_checker u_ibp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
